// ----- sv/fdsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsa_pkg
// Shared types and constants for the Forth data stack with its small ALU.
// ----------------------------------------------------------------------------
package fdsa_pkg;

	localparam int unsigned STACK_DEPTH = 256;
	localparam int unsigned DATA_WIDTH  = 32;
	localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
	localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	// request codes
	typedef enum logic [3:0] {
		REQ_PUSH = 4'd0,
		REQ_ADD  = 4'd1,
		REQ_SUB  = 4'd2,
		REQ_PEEK = 4'd3,
		REQ_DUP  = 4'd4,
		REQ_SWAP = 4'd5,
		REQ_DROP = 4'd6,
		REQ_NPOP = 4'd7,
		REQ_EQ   = 4'd8,
		REQ_LT   = 4'd9,
		REQ_GT   = 4'd10,
		REQ_LE   = 4'd11,
		REQ_GE   = 4'd12
	} req_e;

	// status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_e;

	// controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SWAP2,
		S_NPOP_RD
	} state_e;

	typedef struct packed {
		logic [3:0]              req_type;
		logic signed [31:0]      push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0]      result_value;
		logic                    result_valid;
		logic [DEPTH_W-1:0]      stack_depth;
		logic [1:0]              status;
	} result_t;

	// decision of the execute step, from the ALU to the controller
	typedef struct packed {
		logic                    wr_en;
		logic [ADDR_W-1:0]       wr_addr;
		word_t                   wr_data;
		logic [DEPTH_W-1:0]      new_depth;
		word_t                   res_value;
		status_e                 status;
		logic                    swap2;
		logic                    top_rd;
	} exec_t;

endpackage

// ----- sv/fdsa_stack_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsa_stack_ram
// Stack store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fdsa_stack_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read ports, data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ----- sv/fdsa_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsa_alu
// Execute step: decides writes, new depth, top value and status of a word.
// ----------------------------------------------------------------------------
module fdsa_alu (
	input  fdsa_pkg::req_t                  req,
	input  logic [fdsa_pkg::DEPTH_W-1:0]    depth,
	input  fdsa_pkg::word_t                 second,
	input  fdsa_pkg::word_t                 top,
	output fdsa_pkg::exec_t                 exec
);
	import fdsa_pkg::*;

	localparam int unsigned DIFF_W = DATA_WIDTH + 2;
	localparam logic signed [DIFF_W-1:0] SD_WIDE = DIFF_W'(STACK_DEPTH);

	req_e                      op;
	logic                      empty;
	logic                      one_left;
	logic                      full;
	logic [DEPTH_W-1:0]        rest;
	logic [ADDR_W-1:0]         addr_top;
	logic [ADDR_W-1:0]         addr_second;
	logic [ADDR_W-1:0]         addr_push;
	word_t                     bin_res;
	logic signed [DIFF_W-1:0]  npop_diff;
	logic [DEPTH_W-1:0]        npop_depth;

	assign op          = req_e'(req.req_type);
	assign empty       = (depth == '0);
	assign one_left    = (depth == DEPTH_W'(1));
	assign full        = (depth == DEPTH_W'(STACK_DEPTH));
	assign rest        = depth - DEPTH_W'(1);
	assign addr_top    = rest[ADDR_W-1:0];
	assign addr_second = ADDR_W'(depth - DEPTH_W'(2));
	assign addr_push   = depth[ADDR_W-1:0];

	// binary words: second is the left operand, top the right
	always_comb begin
		case (op)
			REQ_ADD: bin_res = second + top;
			REQ_SUB: bin_res = second - top;
			REQ_EQ:  bin_res = word_t'(second == top);
			REQ_LT:  bin_res = word_t'(second < top);
			REQ_GT:  bin_res = word_t'(top < second);
			REQ_LE:  bin_res = word_t'(!(top < second));
			REQ_GE:  bin_res = word_t'(!(second < top));
			default: bin_res = '0;
		endcase
	end

	// npop: remaining depth minus the count, clamped to 0..STACK_DEPTH
	assign npop_diff = $signed({{(DIFF_W-DEPTH_W){1'b0}}, rest})
		- $signed({{2{top[DATA_WIDTH-1]}}, top});

	always_comb begin
		if (npop_diff[DIFF_W-1]) begin
			npop_depth = '0;
		end else if (npop_diff > SD_WIDE) begin
			npop_depth = DEPTH_W'(STACK_DEPTH);
		end else begin
			npop_depth = npop_diff[DEPTH_W-1:0];
		end
	end

	// per-word decision
	always_comb begin
		exec           = '0;
		exec.new_depth = depth;
		exec.res_value = empty ? '0 : top;
		exec.status    = ST_OK;
		case (op)
			REQ_PUSH: begin
				if (full) begin
					exec.status = ST_OVER;
				end else begin
					exec.wr_en     = 1'b1;
					exec.wr_addr   = addr_push;
					exec.wr_data   = req.push_value;
					exec.new_depth = depth + DEPTH_W'(1);
					exec.res_value = req.push_value;
				end
			end
			REQ_ADD, REQ_SUB, REQ_EQ, REQ_LT, REQ_GT, REQ_LE, REQ_GE: begin
				if (empty) begin
					exec.status = ST_UNDER;
				end else if (one_left) begin
					exec.status    = ST_UNDER;
					exec.new_depth = '0;
					exec.res_value = '0;
				end else begin
					exec.wr_en     = 1'b1;
					exec.wr_addr   = addr_second;
					exec.wr_data   = bin_res;
					exec.new_depth = rest;
					exec.res_value = bin_res;
				end
			end
			REQ_PEEK: begin
				if (empty) begin
					exec.status = ST_UNDER;
				end
			end
			REQ_DUP: begin
				if (empty) begin
					exec.status = ST_UNDER;
				end else if (full) begin
					exec.status = ST_OVER;
				end else begin
					exec.wr_en     = 1'b1;
					exec.wr_addr   = addr_push;
					exec.wr_data   = top;
					exec.new_depth = depth + DEPTH_W'(1);
				end
			end
			REQ_SWAP: begin
				if (empty || one_left) begin
					exec.status = ST_UNDER;
				end else begin
					// old second goes on top now, old top below next cycle
					exec.wr_en     = 1'b1;
					exec.wr_addr   = addr_top;
					exec.wr_data   = second;
					exec.res_value = second;
					exec.swap2     = 1'b1;
				end
			end
			REQ_DROP: begin
				if (empty) begin
					exec.status = ST_UNDER;
				end else begin
					exec.new_depth = rest;
					exec.res_value = one_left ? '0 : second;
				end
			end
			REQ_NPOP: begin
				if (empty) begin
					exec.status = ST_UNDER;
				end else begin
					exec.new_depth = npop_depth;
					exec.res_value = '0;
					exec.top_rd    = (npop_depth != '0);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/forth_data_stack_alu_top.sv -----
`timescale 1ns / 1ps
// Sequence: start is taken in idle, the word runs in the execute state and done
//   is registered from it; swap and an npop that leaves words on the stack pass
//   through one more state (second write or re-read of the new top through the
//   store's read port). A new word is taken only in idle; busy covers the rest.
// Reset: depth goes to 0, then a pass zeroes every store entry with busy high.
// Results are a one-cycle strobe on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// forth_data_stack_alu_top
// Data stack of a Forth-like machine: store in RAM, read-modify-write control.
// ----------------------------------------------------------------------------
module forth_data_stack_alu_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fdsa_pkg::req_t     req,
	output logic               busy,
	output logic               done,
	output fdsa_pkg::result_t  result
);
	import fdsa_pkg::*;

	state_e              state_q;
	state_e              state_d;
	logic [DEPTH_W-1:0]  depth_q;
	logic [ADDR_W-1:0]   clr_q;
	req_t                req_s1;
	result_t             out_q;
	result_t             out_d;
	logic                done_q;
	logic                done_d;
	logic                out_ld;
	logic                depth_ld;
	logic                accept;

	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	word_t               wr_data;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr_a;
	logic [ADDR_W-1:0]   rd_addr_b;
	word_t               rd_a;
	word_t               rd_b;
	exec_t               exec;

	assign accept = start && (state_q == S_IDLE);

	fdsa_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	fdsa_alu u_alu (
		.req    (req_s1),
		.depth  (depth_q),
		.second (rd_a),
		.top    (rd_b),
		.exec   (exec)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(STACK_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (exec.swap2) begin
					state_d = S_SWAP2;
				end else if (exec.top_rd) begin
					state_d = S_NPOP_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SWAP2:   state_d = S_IDLE;
			S_NPOP_RD: state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// store accesses and result load per state
	always_comb begin
		busy      = 1'b1;
		wr_en     = 1'b0;
		wr_addr   = clr_q;
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_addr_a = ADDR_W'(depth_q - DEPTH_W'(2));
		rd_addr_b = ADDR_W'(depth_q - DEPTH_W'(1));
		out_ld    = 1'b0;
		out_d     = out_q;
		done_d    = 1'b0;
		depth_ld  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				busy  = 1'b0;
				rd_en = start;
			end
			S_EXEC: begin
				wr_en              = exec.wr_en;
				wr_addr            = exec.wr_addr;
				wr_data            = exec.wr_data;
				rd_en              = exec.top_rd;
				rd_addr_b          = ADDR_W'(exec.new_depth - DEPTH_W'(1));
				depth_ld           = 1'b1;
				out_ld             = 1'b1;
				out_d.result_value = exec.res_value;
				out_d.result_valid = (exec.new_depth != '0);
				out_d.stack_depth  = exec.new_depth;
				out_d.status       = exec.status;
				done_d             = !(exec.swap2 || exec.top_rd);
			end
			S_SWAP2: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(depth_q - DEPTH_W'(2));
				wr_data = rd_b;
				done_d  = 1'b1;
			end
			S_NPOP_RD: begin
				out_ld             = 1'b1;
				out_d.result_value = rd_b;
				out_d.result_valid = 1'b1;
				out_d.stack_depth  = depth_q;
				out_d.status       = ST_OK;
				done_d             = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			depth_q <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (depth_ld) begin
				depth_q <= exec.new_depth;
			end
		end
	end

	// request and result beats
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (out_ld) begin
			out_q <= out_d;
		end
	end

	assign done   = done_q;
	assign result = out_q;

	// depth stays within the store
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// a result only follows work in progress
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != S_IDLE && $past(state_q) != S_CLEAR)
		else $error("result strobe without a request");

	// words other than swap and npop deliver their beat on time
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type != REQ_SWAP && req.req_type != REQ_NPOP)
		|-> ##2 done)
		else $error("result beat late");

	// overflow only reported with a full stack
	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_OVER)
		|-> result.stack_depth == DEPTH_W'(STACK_DEPTH))
		else $error("overflow with room left");

	// valid flag tracks depth
	a_valid_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.result_valid == (result.stack_depth != '0))
		else $error("valid flag disagrees with depth");

endmodule
